### rtl/lru_key_value_cache_defines.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
`define LKVC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lkvc assertion failed");
`define LKVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT(lbl, clk, rst, prop)
`define LKVC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared constants, request codes and scan status types.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CAP_W         = 5;
   localparam int KEY_W         = 32;
   localparam int VALUE_W       = 32;

   localparam logic [CAP_W-1:0]          CAP_RESET  = 5'd16;
   localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef struct packed {
      logic hit;
      logic victim_found;
      logic free_found;
   } scan_flags_type;

endpackage

`default_nettype wire

### rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each item is a get or a put and yields one result. Entries (key, value and
// age rank) live in a single-port-read, single-port-write memory of DEPTH
// words with a registered read; valid bits are flip-flops cleared by reset.
// An item first scans all entries, one memory read per cycle, then decides
// in a separate state. A get miss finishes there; every other item runs a
// second read-modify-write pass over the memory to update the age ranks.
// The result sits in an output register, so the next item is accepted while
// it waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_type,
   input  wire logic signed [KEY_W-1:0]   req_key,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_hit,
   output logic signed [VALUE_W-1:0]      rsp_read_value,
   output logic                           rsp_evicted,
   output logic signed [KEY_W-1:0]        rsp_evicted_key,
   input  wire logic                      csr_write_enable,
   input  wire logic [CAP_W-1:0]          csr_write_data
);

   localparam int IW    = $clog2(DEPTH);
   localparam int PW    = IW + 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EW    = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int WW    = IW + VALUE_W + KEY_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type            state_ff;
   logic [PW-1:0]        ptr_ff;
   logic [CAP_W-1:0]     cap_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [DEPTH-1:0]     valid_ff;
   logic                 op_put_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic                 do_insert_ff;
   logic [IW-1:0]        ins_idx_ff;
   logic                 res_hit_ff;
   logic [VALUE_W-1:0]   res_value_ff;
   logic                 res_evicted_ff;
   logic [KEY_W-1:0]     res_evkey_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_evicted_ff;
   logic [KEY_W-1:0]     rsp_evkey_ff;

   logic [WW-1:0]        mem_ff [DEPTH];
   logic [WW-1:0]        rdata_ff;

   logic                 req_accept;
   logic [PW-1:0]        ptr_dec;
   logic [IW-1:0]        proc_idx;
   logic                 proc_active;
   logic [IW-1:0]        rd_age;
   logic [VALUE_W-1:0]   rd_value;
   logic [KEY_W-1:0]     rd_key;
   logic                 rd_entry_valid;

   scan_flags_type       flags;
   logic [IW-1:0]        hit_idx;
   logic [IW-1:0]        hit_age;
   logic [VALUE_W-1:0]   hit_value;
   logic [IW-1:0]        victim_idx;
   logic [KEY_W-1:0]     victim_key;
   logic [IW-1:0]        free_idx;

   logic [EW-1:0]        cap_ext;
   logic [EW-1:0]        eff_cap;
   logic                 cap_full;
   logic                 do_insert;
   logic                 do_evict;
   logic [IW-1:0]        ins_idx;
   logic [DEPTH-1:0]     valid_in;

   logic                 wr_en;
   logic [IW-1:0]        new_age;
   logic [VALUE_W-1:0]   new_value;
   logic [KEY_W-1:0]     new_key;
   logic                 rsp_free;

   assign req_accept     = req_valid && !req_stall;
   assign req_stall      = (state_ff != ST_IDLE);
   assign ptr_dec        = ptr_ff - PW'(1);
   assign proc_idx       = ptr_dec[IW-1:0];
   assign proc_active    = (ptr_ff != '0);
   assign rd_age         = rdata_ff[WW-1 -: IW];
   assign rd_value       = rdata_ff[KEY_W +: VALUE_W];
   assign rd_key         = rdata_ff[KEY_W-1:0];
   assign rd_entry_valid = valid_ff[proc_idx];
   assign rsp_free       = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[ptr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[proc_idx] <= {new_age, new_value, new_key};
      end
   end

   lkvc_scan_unit #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .sample      ((state_ff == ST_SCAN) && proc_active),
      .entry_idx   (proc_idx),
      .entry_valid (rd_entry_valid),
      .entry_key   (rd_key),
      .entry_value (rd_value),
      .entry_age   (rd_age),
      .lookup_key  (key_ff),
      .flags       (flags),
      .hit_idx     (hit_idx),
      .hit_age     (hit_age),
      .hit_value   (hit_value),
      .victim_idx  (victim_idx),
      .victim_key  (victim_key),
      .free_idx    (free_idx)
   );

   always_comb begin
      cap_ext = EW'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = EW'(1);
      end else if (cap_ext > EW'(DEPTH)) begin
         eff_cap = EW'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
      cap_full  = (EW'(count_ff) >= eff_cap);
      do_insert = (op_put_ff == REQ_PUT) && !flags.hit;
      do_evict  = do_insert && cap_full && flags.victim_found;
      if (do_evict && !(flags.free_found && free_idx < victim_idx)) begin
         ins_idx = victim_idx;
      end else begin
         ins_idx = free_idx;
      end
      valid_in = valid_ff;
      if (do_insert) begin
         if (do_evict) begin
            valid_in[victim_idx] = 1'b0;
         end
         valid_in[ins_idx] = 1'b1;
      end
   end

   always_comb begin
      new_age   = rd_age;
      new_value = rd_value;
      new_key   = rd_key;
      if (do_insert_ff) begin
         if (proc_idx == ins_idx_ff) begin
            new_age   = '0;
            new_value = value_ff;
            new_key   = key_ff;
         end else if (rd_entry_valid) begin
            new_age = rd_age + IW'(1);
         end
      end else begin
         if (proc_idx == hit_idx) begin
            new_age = '0;
            if (op_put_ff == REQ_PUT) begin
               new_value = value_ff;
            end
         end else if (rd_entry_valid && rd_age < hit_age) begin
            new_age = rd_age + IW'(1);
         end
      end
      wr_en = (state_ff == ST_UPDATE) && proc_active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_put_ff <= req_type;
                  key_ff    <= req_key;
                  value_ff  <= req_value;
                  ptr_ff    <= '0;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               ptr_ff <= ptr_ff + PW'(1);
               if (ptr_ff == PW'(DEPTH)) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               res_hit_ff     <= flags.hit;
               res_value_ff   <= (flags.hit && op_put_ff == REQ_GET) ? hit_value : MISS_VALUE;
               res_evicted_ff <= do_evict;
               res_evkey_ff   <= do_evict ? victim_key : '0;
               do_insert_ff   <= do_insert;
               ins_idx_ff     <= ins_idx;
               valid_ff       <= valid_in;
               if (do_insert && !do_evict) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
               ptr_ff <= '0;
               if (flags.hit || do_insert) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_UPDATE: begin
               ptr_ff <= ptr_ff + PW'(1);
               if (ptr_ff == PW'(DEPTH)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_hit_ff     <= res_hit_ff;
                  rsp_value_ff   <= res_value_ff;
                  rsp_evicted_ff <= res_evicted_ff;
                  rsp_evkey_ff   <= res_evkey_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

   `LKVC_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_accept, state_ff == ST_SCAN)
   `LKVC_ASSERT(a_count_bounded, clock, reset, count_ff <= CNT_W'(DEPTH))
   `LKVC_ASSERT(a_evict_only_on_miss, clock, reset, rsp_valid |-> !(rsp_hit && rsp_evicted))
   `LKVC_ASSERT(a_evkey_zero, clock, reset, (rsp_valid && !rsp_evicted) |-> rsp_evicted_key == '0)

endmodule

`default_nettype wire

### rtl/lkvc_scan_unit.sv
// ----------------------------------------------------------------------------
// LRU key-value cache entry scanner
// Watches the entries streaming out of the store and records the first key
// match, the oldest valid entry and the first free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_scan_unit
   import lkvc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       sample,
   input  wire logic [$clog2(DEPTH)-1:0]   entry_idx,
   input  wire logic                       entry_valid,
   input  wire logic [KEY_W-1:0]           entry_key,
   input  wire logic [VALUE_W-1:0]         entry_value,
   input  wire logic [$clog2(DEPTH)-1:0]   entry_age,
   input  wire logic [KEY_W-1:0]           lookup_key,
   output scan_flags_type                  flags,
   output logic [$clog2(DEPTH)-1:0]        hit_idx,
   output logic [$clog2(DEPTH)-1:0]        hit_age,
   output logic [VALUE_W-1:0]              hit_value,
   output logic [$clog2(DEPTH)-1:0]        victim_idx,
   output logic [KEY_W-1:0]                victim_key,
   output logic [$clog2(DEPTH)-1:0]        free_idx
);

   localparam int IW = $clog2(DEPTH);

   scan_flags_type    flags_ff;
   scan_flags_type    flags_in;
   logic [IW-1:0]     hit_idx_ff;
   logic [IW-1:0]     hit_age_ff;
   logic [VALUE_W-1:0] hit_value_ff;
   logic [IW-1:0]     victim_idx_ff;
   logic [IW-1:0]     victim_age_ff;
   logic [KEY_W-1:0]  victim_key_ff;
   logic [IW-1:0]     free_idx_ff;

   always_comb begin
      flags_in = flags_ff;
      if (sample) begin
         if (entry_valid) begin
            if (entry_key == lookup_key) begin
               flags_in.hit = 1'b1;
            end
            flags_in.victim_found = 1'b1;
         end else begin
            flags_in.free_found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
         if (sample) begin
            if (entry_valid) begin
               if (!flags_ff.hit && entry_key == lookup_key) begin
                  hit_idx_ff   <= entry_idx;
                  hit_age_ff   <= entry_age;
                  hit_value_ff <= entry_value;
               end
               if (!flags_ff.victim_found || entry_age >= victim_age_ff) begin
                  victim_idx_ff <= entry_idx;
                  victim_age_ff <= entry_age;
                  victim_key_ff <= entry_key;
               end
            end else if (!flags_ff.free_found) begin
               free_idx_ff <= entry_idx;
            end
         end
      end
   end

   assign flags      = flags_ff;
   assign hit_idx    = hit_idx_ff;
   assign hit_age    = hit_age_ff;
   assign hit_value  = hit_value_ff;
   assign victim_idx = victim_idx_ff;
   assign victim_key = victim_key_ff;
   assign free_idx   = free_idx_ff;

endmodule

`default_nettype wire

### tb/sv/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Sends get and put items in bursts while the result side stalls on a
// pattern of its own. A directed table opens the run, then random phases
// follow, each under a capacity set at its start. Every result is compared
// field by field against a table entry or a software LRU copy of the store.
// ----------------------------------------------------------------------------

module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   localparam int ITEMS_PER_PHASE = 150;
   localparam int PHASE_COUNT     = 8;
   localparam int POOL_SIZE       = 24;
   localparam int TABLE_ROWS      = 24;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
      logic               evicted;
      logic [KEY_W-1:0]   evicted_key;
   } cache_rsp_type;

   typedef struct packed {
      logic               is_cfg;
      logic [CAP_W-1:0]   capacity;
      logic               kind;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               typed;
      cache_rsp_type      rsp;
   } stim_row_type;

   localparam cache_rsp_type MISS_RSP = '{1'b0, MISS_VALUE, 1'b0, 32'h0};
   localparam cache_rsp_type NO_RSP   = '{1'b0, 32'h0, 1'b0, 32'h0};

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_type;
   logic signed [KEY_W-1:0]   req_key;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_hit;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic                      rsp_evicted;
   logic signed [KEY_W-1:0]   rsp_evicted_key;
   logic                      csr_write_enable;
   logic [CAP_W-1:0]          csr_write_data;

   logic [KEY_W-1:0]   cached_keys   [0:DEPTH_DEFAULT-1];
   logic [VALUE_W-1:0] cached_values [0:DEPTH_DEFAULT-1];
   bit                 cached_live   [0:DEPTH_DEFAULT-1];
   int                 cached_rank   [0:DEPTH_DEFAULT-1];
   int                 cached_count;
   logic [CAP_W-1:0]   capacity_setting;

   cache_rsp_type      pending_responses [$];
   int                 mismatch_count = 0;
   stim_row_type       stimulus_table [0:TABLE_ROWS-1];
   logic [CAP_W-1:0]   phase_capacity [0:PHASE_COUNT-1];
   logic [KEY_W-1:0]   key_pool [0:POOL_SIZE-1];

   lru_key_value_cache dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_key  (rsp_evicted_key),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic cache_rsp_type predict_access(input logic kind,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [VALUE_W-1:0] value);
      cache_rsp_type rsp;
      int            slot;
      int            victim;
      int            free_slot;
      int            old_rank;
      int            limit;
      rsp       = MISS_RSP;
      slot      = -1;
      victim    = -1;
      free_slot = -1;
      for (int i = 0; i < DEPTH_DEFAULT; i++) begin
         if (slot < 0 && cached_live[i] && cached_keys[i] == key) slot = i;
      end
      if (slot >= 0) begin
         rsp.hit = 1'b1;
         if (kind == REQ_PUT) cached_values[slot] = value;
         else rsp.read_value = cached_values[slot];
         old_rank = cached_rank[slot];
         for (int i = 0; i < DEPTH_DEFAULT; i++) begin
            if (cached_live[i] && cached_rank[i] < old_rank) cached_rank[i]++;
         end
         cached_rank[slot] = 0;
      end else if (kind == REQ_PUT) begin
         if (capacity_setting == 0) limit = 1;
         else if (capacity_setting > DEPTH_DEFAULT) limit = DEPTH_DEFAULT;
         else limit = capacity_setting;
         if (cached_count >= limit) begin
            for (int i = 0; i < DEPTH_DEFAULT; i++) begin
               if (cached_live[i] && (victim < 0 || cached_rank[i] >= cached_rank[victim]))
                  victim = i;
            end
            if (victim >= 0) begin
               cached_live[victim] = 1'b0;
               rsp.evicted         = 1'b1;
               rsp.evicted_key     = cached_keys[victim];
               if (cached_count > 0) cached_count--;
            end
         end
         for (int i = 0; i < DEPTH_DEFAULT; i++) begin
            if (free_slot < 0 && !cached_live[i]) free_slot = i;
         end
         if (free_slot >= 0) begin
            for (int i = 0; i < DEPTH_DEFAULT; i++) begin
               if (cached_live[i]) cached_rank[i]++;
            end
            cached_live[free_slot]   = 1'b1;
            cached_keys[free_slot]   = key;
            cached_values[free_slot] = value;
            cached_rank[free_slot]   = 0;
            cached_count++;
         end
      end
      return rsp;
   endfunction

   task automatic idle_cycles(input int count);
      repeat (count) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value, input logic typed,
                               input cache_rsp_type typed_rsp);
      cache_rsp_type predicted;
      @(negedge clock);
      req_valid <= 1'b1;
      req_type  <= kind;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      predicted = predict_access(kind, key, value);
      pending_responses.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] capacity);
      idle_cycles(1);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (2 * DEPTH_DEFAULT + 4) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= capacity;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      capacity_setting = capacity;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %h actual %h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : response_check
      cache_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            $error("result item with nothing outstanding: hit %b read_value %h",
                   rsp_hit, rsp_read_value);
            mismatch_count++;
         end else begin
            want = pending_responses.pop_front();
            check_field("hit", want.hit, rsp_hit);
            check_field("read_value", want.read_value, rsp_read_value);
            check_field("evicted", want.evicted, rsp_evicted);
            check_field("evicted_key", want.evicted_key, rsp_evicted_key);
         end
      end
   end

   initial begin : receiver_stall_pattern
      int run_len;
      int mode;
      int step;
      rsp_stall = 1'b0;
      step      = 0;
      forever begin
         run_len = $urandom_range(1, 60);
         mode    = $urandom_range(0, 3);
         repeat (run_len) begin
            @(negedge clock);
            step++;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'b1;
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= (step % 3 == 0);
            endcase
         end
      end
   end

   initial begin : run_limit
      #2000000;
      $display("lru_key_value_cache: mismatch");
      $finish;
   end

   initial begin : stimulus
      int               pool_top;
      int               sent;
      int               burst;
      logic [KEY_W-1:0] key;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_GET;
      req_key          = '0;
      req_value        = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      cached_count     = 0;
      capacity_setting = CAP_RESET;
      for (int i = 0; i < DEPTH_DEFAULT; i++) begin
         cached_live[i] = 1'b0;
         cached_rank[i] = 0;
      end

      phase_capacity = '{5'd16, 5'd1, 5'd5, 5'd16, 5'd2, 5'd12, 5'd8, 5'd16};
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      stimulus_table = '{
         '{1'b0, 5'd0, REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS_RSP},
         '{1'b0, 5'd0, REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, MISS_RSP},
         '{1'b0, 5'd0, REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, MISS_RSP},
         '{1'b0, 5'd0, REQ_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
           '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
         '{1'b0, 5'd0, REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
           '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
         '{1'b0, 5'd0, REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, MISS_RSP},
         '{1'b0, 5'd0, REQ_GET, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
           '{1'b1, 32'h0000_0000, 1'b0, 32'h0}},
         '{1'b0, 5'd0, REQ_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
           '{1'b1, MISS_VALUE, 1'b0, 32'h0}},
         '{1'b0, 5'd0, REQ_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
           '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
         '{1'b0, 5'd0, REQ_GET, 32'h0000_0005, 32'h0000_0000, 1'b1, MISS_RSP},
         '{1'b1, 5'd1, REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_RSP},
         '{1'b0, 5'd0, REQ_PUT, 32'h0000_0000, 32'h0000_007B, 1'b0, NO_RSP},
         '{1'b0, 5'd0, REQ_PUT, 32'h0000_0001, 32'h0000_0001, 1'b0, NO_RSP},
         '{1'b0, 5'd0, REQ_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, NO_RSP},
         '{1'b0, 5'd0, REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, NO_RSP},
         '{1'b1, 5'd2, REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_RSP},
         '{1'b0, 5'd0, REQ_PUT, 32'h0000_0002, 32'h0000_0002, 1'b0, NO_RSP},
         '{1'b0, 5'd0, REQ_PUT, 32'h0000_0003, 32'h0000_0003, 1'b0, NO_RSP},
         '{1'b0, 5'd0, REQ_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, NO_RSP},
         '{1'b0, 5'd0, REQ_PUT, 32'h0000_0004, 32'h0000_0004, 1'b0, NO_RSP},
         '{1'b1, 5'd16, REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_RSP},
         '{1'b0, 5'd0, REQ_PUT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, MISS_RSP},
         '{1'b0, 5'd0, REQ_GET, 32'hAAAA_AAAA, 32'h0000_0000, 1'b1, MISS_RSP},
         '{1'b0, 5'd0, REQ_GET, 32'h5555_5555, 32'h0000_0000, 1'b1,
           '{1'b1, 32'hAAAA_AAAA, 1'b0, 32'h0}}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < TABLE_ROWS; r++) begin
         if (stimulus_table[r].is_cfg) begin
            write_capacity(stimulus_table[r].capacity);
         end else begin
            send_request(stimulus_table[r].kind, stimulus_table[r].key,
                         stimulus_table[r].value, stimulus_table[r].typed,
                         stimulus_table[r].rsp);
            idle_cycles($urandom_range(0, 2));
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_capacity(phase_capacity[p]);
         pool_top = (phase_capacity[p] + 4 > POOL_SIZE - 1) ? POOL_SIZE - 1
                                                            : phase_capacity[p] + 4;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
               if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_top)];
               else key = $urandom;
               send_request(1'($urandom_range(0, 1)), key, $urandom, 1'b0, NO_RSP);
               sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 30));
         end
      end

      idle_cycles(1);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (2 * DEPTH_DEFAULT + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("lru_key_value_cache: match");
      end else begin
         $display("lru_key_value_cache: mismatch");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lkvc_scan_unit.sv
rtl/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_tb.sv
